>>> rtl/h2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h2s_pkg;

  // Kind of request on the input channel.
  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_BYTE   = 1'b1
  } h2s_cmd_e;

  // Status reported with each result.
  typedef enum logic [2:0] {
    ST_APPLIED    = 3'd0,
    ST_ACK        = 3'd1,
    ST_FRAME_SIZE = 3'd2,
    ST_PROTOCOL   = 3'd3,
    ST_CLOSED     = 3'd4
  } h2s_status_e;

  // Frame progress: waiting for a header, collecting entries, or dropping bytes.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } h2s_phase_e;

  // Setting identifiers carried in each entry.
  localparam logic [15:0] ID_TABLE_SIZE  = 16'd1;
  localparam logic [15:0] ID_ENABLE_PUSH = 16'd2;
  localparam logic [15:0] ID_STREAMS     = 16'd3;
  localparam logic [15:0] ID_WINDOW      = 16'd4;
  localparam logic [15:0] ID_FRAME_SIZE  = 16'd5;
  localparam logic [15:0] ID_LIST_SIZE   = 16'd6;

  // Protocol defaults loaded at reset.
  localparam logic [31:0] DefTableSize = 32'd4096;
  localparam logic        DefPush      = 1'b1;
  localparam logic [31:0] DefStreams   = 32'd2147483647;
  localparam logic [31:0] DefWindow    = 32'd65535;
  localparam logic [31:0] DefFrameSize = 32'd16384;
  localparam logic [31:0] DefListSize  = 32'd2147483647;

  // One entry is six bytes; the position counter counts 0 to EntryLastPos.
  localparam int unsigned EntryBytes   = 6;
  localparam logic [2:0]  EntryLastPos = 3'(EntryBytes - 1);

  typedef struct packed {
    h2s_cmd_e    command;
    logic        ack_flag;
    logic [30:0] strm_ident;
    logic [23:0] payload_length;
    logic        conn_closed;
    logic [7:0]  data_byte;
  } h2s_in_req_t;

  typedef struct packed {
    h2s_status_e status;
    logic [31:0] peer_hdr_tbl_sz;
    logic        push_allowed;
    logic [31:0] stream_limit;
    logic [31:0] start_window;
    logic [31:0] frame_limit;
    logic [31:0] hdr_list_limit;
    logic        decoder_table_reset;
    logic        encoder_table_reset;
  } h2s_out_req_t;

  // Verdict of the header checks.
  typedef struct packed {
    logic        emit;
    h2s_status_e status;
    logic        dec_reset;
    logic        enc_reset;
    h2s_phase_e  phase;
  } h2s_hdr_res_t;

endpackage

`default_nettype wire

>>> rtl/http2_settings_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// A request is held in the input register; any result it yields then goes to
// the result register. Throughput: one request per cycle, header or payload
// byte; input stall rises only while a result is held back.
// Reset loads the protocol defaults into the six settings and returns the
// frame tracker to idle; no clearing pass is needed.

module http2_settings_frame_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  h2s_pkg::h2s_in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output h2s_pkg::h2s_out_req_t out_req_o
);
  import h2s_pkg::*;

  // Input stage.
  h2s_in_req_t item_q;
  logic        item_vld_q;
  logic        advance;
  logic        in_accept;

  // Result stage.
  h2s_out_req_t out_q, res;
  logic         out_vld_q;
  logic         res_vld;

  // Settings and frame tracking state.
  logic [31:0] table_size_q, table_size_d;
  logic        push_q, push_d;
  logic [31:0] streams_q, streams_d;
  logic [31:0] window_q, window_d;
  logic [31:0] frame_size_q, frame_size_d;
  logic [31:0] list_size_q, list_size_d;
  logic [23:0] bytes_left_q, bytes_left_d;
  logic [39:0] entry_shift_q, entry_shift_d;
  logic [2:0]  entry_pos_q, entry_pos_d;
  h2s_phase_e  phase_q, phase_d;

  logic [47:0]  shift_nx;
  logic [23:0]  left_nx;
  logic         bad_push;
  h2s_hdr_res_t hdr_res;

  h2s_hdr_check u_hdr_check (
    .req_i (item_q),
    .res_o (hdr_res)
  );

  // The input register moves on when the result register is free or drained.
  assign advance    = item_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = item_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_accept) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_req_i;
    end
  end

  // Process the held request against the current state.
  always_comb begin
    table_size_d  = table_size_q;
    push_d        = push_q;
    streams_d     = streams_q;
    window_d      = window_q;
    frame_size_d  = frame_size_q;
    list_size_d   = list_size_q;
    bytes_left_d  = bytes_left_q;
    entry_shift_d = entry_shift_q;
    entry_pos_d   = entry_pos_q;
    phase_d       = phase_q;
    res_vld       = 1'b0;
    bad_push      = 1'b0;
    res.status              = ST_APPLIED;
    res.decoder_table_reset = 1'b0;
    res.encoder_table_reset = 1'b0;

    shift_nx = {entry_shift_q, item_q.data_byte};
    left_nx  = (bytes_left_q != '0) ? (bytes_left_q - 24'd1) : '0;

    if (advance) begin
      if (item_q.command == CMD_HEADER) begin
        entry_shift_d = '0;
        entry_pos_d   = '0;
        bytes_left_d  = item_q.payload_length;
        phase_d       = hdr_res.phase;
        res_vld       = hdr_res.emit;
        res.status              = hdr_res.status;
        res.decoder_table_reset = hdr_res.dec_reset;
        res.encoder_table_reset = hdr_res.enc_reset;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            bytes_left_d = bytes_left_q;
          end
          PH_PAYLOAD: begin
            bytes_left_d = left_nx;
            if (entry_pos_q == EntryLastPos) begin
              // A complete entry: apply it to its setting.
              entry_pos_d   = '0;
              entry_shift_d = '0;
              case (shift_nx[47:32])
                ID_TABLE_SIZE: table_size_d = shift_nx[31:0];
                ID_ENABLE_PUSH: begin
                  if (shift_nx[31:1] != '0) begin
                    bad_push = 1'b1;
                  end else begin
                    push_d = shift_nx[0];
                  end
                end
                ID_STREAMS:    streams_d    = shift_nx[31:0];
                ID_WINDOW:     window_d     = shift_nx[31:0];
                ID_FRAME_SIZE: frame_size_d = shift_nx[31:0];
                ID_LIST_SIZE:  list_size_d  = shift_nx[31:0];
                default:       table_size_d = table_size_q;
              endcase
              if (bad_push) begin
                phase_d    = (left_nx == '0) ? PH_IDLE : PH_DISCARD;
                res_vld    = 1'b1;
                res.status = ST_PROTOCOL;
              end else if (left_nx == '0) begin
                phase_d                 = PH_IDLE;
                res_vld                 = 1'b1;
                res.decoder_table_reset = 1'b1;
              end
            end else begin
              entry_shift_d = shift_nx[39:0];
              entry_pos_d   = entry_pos_q + 3'd1;
            end
          end
          default: begin
            // Dropping the rest of a rejected frame.
            bytes_left_d = left_nx;
            if (left_nx == '0) begin
              phase_d = PH_IDLE;
            end
          end
        endcase
      end
    end

    res.peer_hdr_tbl_sz = table_size_d;
    res.push_allowed    = push_d;
    res.stream_limit    = streams_d;
    res.start_window    = window_d;
    res.frame_limit     = frame_size_d;
    res.hdr_list_limit  = list_size_d;
  end

  // Settings and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= DefTableSize;
      push_q       <= DefPush;
      streams_q    <= DefStreams;
      window_q     <= DefWindow;
      frame_size_q <= DefFrameSize;
      list_size_q  <= DefListSize;
      bytes_left_q <= '0;
      entry_pos_q  <= '0;
      phase_q      <= PH_IDLE;
    end else begin
      table_size_q <= table_size_d;
      push_q       <= push_d;
      streams_q    <= streams_d;
      window_q     <= window_d;
      frame_size_q <= frame_size_d;
      list_size_q  <= list_size_d;
      bytes_left_q <= bytes_left_d;
      entry_pos_q  <= entry_pos_d;
      phase_q      <= phase_d;
    end
  end

  // Entry assembly register; a header always clears it before use.
  always_ff @(posedge clk_i) begin
    entry_shift_q <= entry_shift_d;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/h2s_hdr_check.sv
`timescale 1ns / 1ps
`default_nettype none

module h2s_hdr_check (
  input  h2s_pkg::h2s_in_req_t  req_i,
  output h2s_pkg::h2s_hdr_res_t res_o
);
  import h2s_pkg::*;

  // Residue modulo 3 of a 4-bit value.
  function automatic logic [1:0] mod3_nib(input logic [3:0] v);
    logic [1:0] r;
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

  localparam int unsigned NumNibbles = 6;

  logic [3:0] res_sum;
  logic       len_mult6;

  // Since 16 is 1 modulo 3, the residues of the six nibbles add up to the
  // residue of the whole length. Even and divisible by 3 means divisible by 6.
  always_comb begin
    res_sum = '0;
    for (int i = 0; i < NumNibbles; i++) begin
      res_sum = res_sum + {2'b00, mod3_nib(req_i.payload_length[4*i +: 4])};
    end
    len_mult6 = !req_i.payload_length[0] && (mod3_nib(res_sum) == 2'd0);
  end

  // Header checks in priority order.
  always_comb begin
    res_o.emit      = 1'b1;
    res_o.status    = ST_APPLIED;
    res_o.dec_reset = 1'b0;
    res_o.enc_reset = 1'b0;
    res_o.phase     = PH_DISCARD;
    if (req_i.conn_closed) begin
      res_o.status = ST_CLOSED;
    end else if (req_i.ack_flag) begin
      if (req_i.payload_length != '0) begin
        res_o.status = ST_FRAME_SIZE;
      end else begin
        res_o.status    = ST_ACK;
        res_o.enc_reset = 1'b1;
        res_o.phase     = PH_IDLE;
      end
    end else if (req_i.strm_ident != '0) begin
      res_o.status = ST_PROTOCOL;
    end else if (!len_mult6) begin
      res_o.status = ST_FRAME_SIZE;
    end else if (req_i.payload_length == '0) begin
      res_o.dec_reset = 1'b1;
      res_o.phase     = PH_IDLE;
    end else begin
      res_o.emit  = 1'b0;
      res_o.phase = PH_PAYLOAD;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_http2_settings_frame_parser.sv
`timescale 1ns / 1ps

module tb_http2_settings_frame_parser;
  import h2s_pkg::*;

  localparam int unsigned RandomItems   = 600;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  typedef logic [47:0] entry_q_t[$];

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  h2s_in_req_t  in_req;
  logic         out_valid;
  logic         out_stall;
  h2s_out_req_t out_req;

  // Predicted peer settings and frame tracker.
  logic [31:0] peer_table_size = DefTableSize;
  logic        peer_push       = DefPush;
  logic [31:0] peer_streams    = DefStreams;
  logic [31:0] peer_window     = DefWindow;
  logic [31:0] peer_frame_size = DefFrameSize;
  logic [31:0] peer_list_size  = DefListSize;
  logic [23:0] bytes_remaining = '0;
  logic [47:0] entry_bits      = '0;
  logic [2:0]  entry_count     = '0;
  h2s_phase_e  tracker_phase   = PH_IDLE;

  h2s_out_req_t expected_settings_results[$];
  int unsigned  mismatches      = 0;
  int unsigned  requests_in_use = 0;
  int unsigned  burst_left      = 0;

  http2_settings_frame_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the predicted state by one request; returns 1 unless the block ignores it.
  function automatic bit predict_settings_update(input h2s_in_req_t req);
    h2s_out_req_t res;
    logic [15:0]  id;
    logic [31:0]  val;
    bit           produce;
    bit           used;
    produce = 1'b0;
    used    = 1'b1;
    res     = '0;
    if (req.command == CMD_HEADER) begin
      entry_bits      = '0;
      entry_count     = '0;
      bytes_remaining = req.payload_length;
      tracker_phase   = PH_DISCARD;
      produce         = 1'b1;
      if (req.conn_closed) begin
        res.status = ST_CLOSED;
      end else if (req.ack_flag) begin
        if (req.payload_length != 0) begin
          res.status = ST_FRAME_SIZE;
        end else begin
          res.status              = ST_ACK;
          res.encoder_table_reset = 1'b1;
          tracker_phase           = PH_IDLE;
        end
      end else if (req.strm_ident != 0) begin
        res.status = ST_PROTOCOL;
      end else if ((req.payload_length % EntryBytes) != 0) begin
        res.status = ST_FRAME_SIZE;
      end else if (req.payload_length == 0) begin
        res.status              = ST_APPLIED;
        res.decoder_table_reset = 1'b1;
        tracker_phase           = PH_IDLE;
      end else begin
        produce       = 1'b0;
        tracker_phase = PH_PAYLOAD;
      end
    end else if (tracker_phase == PH_IDLE) begin
      used = 1'b0;
    end else begin
      if (bytes_remaining != 0) bytes_remaining = bytes_remaining - 1'b1;
      if (tracker_phase != PH_PAYLOAD) begin
        used = 1'b0;
        if (bytes_remaining == 0) tracker_phase = PH_IDLE;
      end else begin
        entry_bits  = {entry_bits[39:0], req.data_byte};
        entry_count = entry_count + 1'b1;
        if (entry_count >= EntryBytes) begin
          id          = entry_bits[47:32];
          val         = entry_bits[31:0];
          entry_bits  = '0;
          entry_count = '0;
          case (id)
            ID_TABLE_SIZE: peer_table_size = val;
            ID_ENABLE_PUSH: begin
              if (val > 1) begin
                produce       = 1'b1;
                res.status    = ST_PROTOCOL;
                tracker_phase = (bytes_remaining == 0) ? PH_IDLE : PH_DISCARD;
              end else begin
                peer_push = val[0];
              end
            end
            ID_STREAMS:    peer_streams    = val;
            ID_WINDOW:     peer_window     = val;
            ID_FRAME_SIZE: peer_frame_size = val;
            ID_LIST_SIZE:  peer_list_size  = val;
            default: ;
          endcase
          if (!produce && bytes_remaining == 0) begin
            produce                 = 1'b1;
            res.status              = ST_APPLIED;
            res.decoder_table_reset = 1'b1;
            tracker_phase           = PH_IDLE;
          end
        end
      end
    end
    if (produce) begin
      res.peer_hdr_tbl_sz = peer_table_size;
      res.push_allowed    = peer_push;
      res.stream_limit    = peer_streams;
      res.start_window    = peer_window;
      res.frame_limit     = peer_frame_size;
      res.hdr_list_limit  = peer_list_size;
      expected_settings_results.push_back(res);
    end
    return used;
  endfunction

  // Header request; the unused byte field carries random noise.
  function automatic h2s_in_req_t make_header(input logic ack, input logic [30:0] sid,
                                              input logic [23:0] len, input logic closed);
    h2s_in_req_t req;
    req.command        = CMD_HEADER;
    req.ack_flag       = ack;
    req.strm_ident     = sid;
    req.payload_length = len;
    req.conn_closed    = closed;
    req.data_byte      = 8'($urandom);
    return req;
  endfunction

  // Payload byte request; the header fields carry random noise.
  function automatic h2s_in_req_t make_byte(input logic [7:0] data);
    h2s_in_req_t req;
    req.command        = CMD_BYTE;
    req.ack_flag       = 1'($urandom);
    req.strm_ident     = 31'($urandom);
    req.payload_length = 24'($urandom);
    req.conn_closed    = 1'($urandom);
    req.data_byte      = data;
    return req;
  endfunction

  // Drive one request at the falling edge and hold it until accepted.
  task automatic send_request(input h2s_in_req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req   = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_settings_update(req)) requests_in_use++;
    burst_left--;
  endtask

  // Send the first nbytes of a list of entries, big-endian.
  task automatic send_entries(input entry_q_t entries, input int unsigned nbytes);
    logic [47:0] entry;
    int unsigned i;
    for (i = 0; i < nbytes; i++) begin
      entry = entries[i / EntryBytes];
      send_request(make_byte(entry[47 - 8 * (i % EntryBytes) -: 8]));
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] random_entry();
    logic [15:0] id;
    logic [31:0] val;
    case ($urandom_range(0, 8))
      0: id = ID_TABLE_SIZE;
      1: id = ID_ENABLE_PUSH;
      2: id = ID_STREAMS;
      3: id = ID_WINDOW;
      4: id = ID_FRAME_SIZE;
      5: id = ID_LIST_SIZE;
      6: id = '0;
      7: id = '1;
      default: id = 16'($urandom_range(ID_LIST_SIZE + 1, 16'hFFFF));
    endcase
    // Push values stay legal most of the time so frames run to completion.
    if (id == ID_ENABLE_PUSH && $urandom_range(0, 3) != 0) val = $urandom_range(0, 1);
    else val = pick_value();
    return {id, val};
  endfunction

  // Header checks in priority order, plus a stray byte while idle.
  task automatic test_header_checks();
    send_request(make_header(1'b1, '1, 24'd1, 1'b1));
    send_request(make_byte('1));
    send_request(make_header(1'b1, '0, 24'(EntryBytes), 1'b0));
    send_request(make_header(1'b1, '0, '0, 1'b0));
    send_request(make_header(1'b0, '1, '0, 1'b0));
    send_request(make_header(1'b0, '0, '1, 1'b0));
    send_request(make_header(1'b0, '0, '0, 1'b0));
    send_request(make_byte('0));
  endtask

  task automatic test_single_entry();
    entry_q_t entries;
    entries.push_back({ID_TABLE_SIZE, 32'hFFFF_FFFF});
    send_request(make_header(1'b0, '0, 24'(EntryBytes), 1'b0));
    send_entries(entries, EntryBytes);
  endtask

  // Illegal push value mid-frame, then a header that abandons a partial entry.
  task automatic test_push_error_and_abandon();
    entry_q_t entries;
    entries.push_back({ID_ENABLE_PUSH, 32'd2});
    entries.push_back({ID_STREAMS, 32'd0});
    send_request(make_header(1'b0, '0, 24'(2 * EntryBytes), 1'b0));
    send_entries(entries, EntryBytes + 1);
    entries.delete();
    entries.push_back({ID_WINDOW, 32'd0});
    send_request(make_header(1'b0, '0, 24'(EntryBytes), 1'b0));
    send_entries(entries, 2);
    send_request(make_header(1'b0, '0, '0, 1'b0));
  endtask

  // Mostly well-formed frames with random entries, mixed with broken frames and noise.
  task automatic test_random_frames();
    entry_q_t    entries;
    int unsigned start;
    int unsigned kind;
    int unsigned count;
    int unsigned cut;
    logic [23:0] len;
    start = requests_in_use;
    while (requests_in_use - start < RandomItems) begin
      kind = $urandom_range(0, 19);
      entries.delete();
      if (kind < 13) begin
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (count) entries.push_back(random_entry());
        send_request(make_header(1'b0, '0, 24'(count * EntryBytes), 1'b0));
        cut = count * EntryBytes;
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, cut);
        send_entries(entries, cut);
      end else if (kind < 17) begin
        len = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
        case ($urandom_range(0, 3))
          0: send_request(make_header(1'($urandom), 31'($urandom), len, 1'b1));
          1: send_request(make_header(1'b1, 31'($urandom), len, 1'b0));
          2: send_request(make_header(1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF)), len, 1'b0));
          default: send_request(make_header(1'b0, '0, len, 1'b0));
        endcase
        repeat ($urandom_range(0, 8)) send_request(make_byte(8'($urandom)));
      end else if (kind < 19) begin
        send_request(make_header(1'b1, '0, '0, 1'b0));
      end else begin
        repeat ($urandom_range(1, 3)) send_request(make_byte(8'($urandom)));
      end
    end
  endtask

  // Receiver stall pattern: spans of no stall, light, heavy, or periodic stalls.
  initial begin : stall_pattern
    int unsigned mode;
    int unsigned span;
    int unsigned step;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (step = 0; step < span; step++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ((step % 5) < 3);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    h2s_out_req_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_settings_results.size() == 0) begin
        $error("unexpected result with status %0d", out_req.status);
        mismatches++;
      end else begin
        exp_res = expected_settings_results.pop_front();
        check_field("status", 32'(exp_res.status), 32'(out_req.status));
        check_field("peer_hdr_tbl_sz", exp_res.peer_hdr_tbl_sz,
                    out_req.peer_hdr_tbl_sz);
        check_field("push_allowed", 32'(exp_res.push_allowed),
                    32'(out_req.push_allowed));
        check_field("stream_limit", exp_res.stream_limit, out_req.stream_limit);
        check_field("start_window", exp_res.start_window, out_req.start_window);
        check_field("frame_limit", exp_res.frame_limit, out_req.frame_limit);
        check_field("hdr_list_limit", exp_res.hdr_list_limit, out_req.hdr_list_limit);
        check_field("decoder_table_reset", 32'(exp_res.decoder_table_reset),
                    32'(out_req.decoder_table_reset));
        check_field("encoder_table_reset", 32'(exp_res.encoder_table_reset),
                    32'(out_req.encoder_table_reset));
      end
    end
  end

  // End the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("http2_settings_frame_parser regression: fail");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_header_checks();
    test_single_entry();
    test_push_error_and_abandon();
    test_random_frames();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_settings_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("http2_settings_frame_parser regression: pass");
    end else begin
      $display("http2_settings_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
